// ----- rtl/ssum_pkg.sv -----
// Shared field widths and result type for the subset sum solver.
package ssum_pkg;

	localparam int WEIGHT_W = 16;
	localparam int TARGET_W = 10;
	localparam int INDEX_W  = 5;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 8;

	typedef struct packed {
		logic               found;
		logic [INDEX_W-1:0] item_index;
		logic               chosen;
		logic               last_result;
	} ssum_res_t;

endpackage

// ----- rtl/subset_sum_solver_core.sv -----
// Subset sum solver: weight loading, table fill, traceback and result emission.
//
// Usage:
//  s_* carries one weight per transfer (s_tdata[15:0]); s_tlast marks the final
//  item and starts solving against the target held by the cfg_* write channel.
//  Items beyond MAX_ITEMS are dropped, though a dropped item with s_tlast still
//  starts the solve. While loading, one weight is taken per cycle.
//  After the final item s_tready stays low until the last result is registered.
//  With n = items, the solve fills the table row by row: row 0 and column 0
//  are written directly, every other bit is read and then written through the
//  one table write port and the shared subtractor; the target check reads the
//  final bit, and the traceback reads one bit per item visited until the
//  remaining sum or row reaches zero.
//  Results then leave on m_* at up to one per cycle: n flags in load order,
//  or a single no-solution result (m_tuser low). m_tlast marks the final one.
//  A stalled receiver holds the output register; the sequencer waits on it.
//  The table needs no clearing: each run writes every entry it reads.
//  Reset empties the item count, clears the target and drops any pending result.
//  cfg_ready is always high; write the target only while the block is idle.
module subset_sum_solver_core
	import ssum_pkg::*;
#(
	parameter int MAX_ITEMS = 32,
	parameter int MAX_SUM   = 1023
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] weight
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [4:0] item_index, [5] chosen, [7:6] zero
	output logic                  m_tuser,   // [0] found
	output logic                  m_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [TARGET_W-1:0]   cfg_data
);

	localparam int RW = $clog2(MAX_ITEMS + 1);
	localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_SUM + 1);
	localparam int AW = RW + CW;
	localparam int TW = (CW > TARGET_W) ? CW : TARGET_W;
	localparam int SW = ((CW > WEIGHT_W) ? CW : WEIGHT_W) + 1;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_ROW0,
		ST_WRD,
		ST_FILL0,
		ST_FRD,
		ST_FWR,
		ST_CHK_RD,
		ST_CHK_EV,
		ST_TB_RD,
		ST_TB_EV,
		ST_EMIT
	} state_t;

	state_t               state_q;
	logic [RW-1:0]        cnt_q;
	logic [RW-1:0]        n_q;
	logic [RW-1:0]        row_q;
	logic [CW-1:0]        col_q;       // column during fill, remaining sum during traceback
	logic [IW-1:0]        idx_q;
	logic [MAX_ITEMS-1:0] flags_q;
	logic                 nosol_q;
	logic [TARGET_W-1:0]  target_q;
	logic                 m_tvalid_q;
	ssum_res_t            res_q;

	logic [WEIGHT_W-1:0]  wmem [MAX_ITEMS];
	logic [WEIGHT_W-1:0]  w_rd_q;

	logic [RW-1:0]        rowm1;
	logic [IW-1:0]        w_raddr;
	logic [TW-1:0]        tgt_w;
	logic                 too_big;
	logic [CW-1:0]        tgt_c;
	logic                 room;
	logic [RW-1:0]        cnt_next;
	logic [SW-1:0]        diff;
	logic                 ge;
	logic                 emit_last;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic                 ram_wdata;
	logic [AW-1:0]        ram_raddr_a;
	logic [AW-1:0]        ram_raddr_b;
	logic                 rd_a;
	logic                 rd_b;

	assign rowm1    = row_q - RW'(1);
	assign w_raddr  = rowm1[IW-1:0];
	assign tgt_w    = TW'(target_q);
	assign too_big  = tgt_w > TW'(MAX_SUM);
	assign tgt_c    = tgt_w[CW-1:0];
	assign room     = cnt_q < RW'(MAX_ITEMS);
	assign cnt_next = cnt_q + RW'(room);

	// shared subtractor: column minus weight in fill, remainder minus weight in traceback
	assign diff = SW'(col_q) - SW'(w_rd_q);
	assign ge   = ~diff[SW-1];

	assign emit_last = (RW'(idx_q) + RW'(1)) == n_q;

	assign s_tready  = (state_q == ST_LOAD);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tuser   = res_q.found;
	assign m_tlast   = res_q.last_result;
	assign m_tdata   = OUT_DATA_W'({res_q.chosen, res_q.item_index});

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready && room) begin
			wmem[cnt_q[IW-1:0]] <= s_tdata[WEIGHT_W-1:0];
		end
		w_rd_q <= wmem[w_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (cfg_valid) begin
			target_q <= cfg_data;
		end
	end

	always_comb begin
		ram_we      = 1'b0;
		ram_wdata   = 1'b0;
		ram_waddr   = {row_q, col_q};
		ram_raddr_a = {rowm1, col_q};
		ram_raddr_b = {rowm1, diff[CW-1:0]};
		unique case (state_q)
			ST_ROW0: begin
				ram_we    = 1'b1;
				ram_wdata = (col_q == '0);
			end
			ST_FILL0: begin
				ram_we    = 1'b1;
				ram_wdata = 1'b1;
			end
			ST_FWR: begin
				ram_we    = 1'b1;
				ram_wdata = rd_a | (ge & rd_b);
			end
			ST_CHK_RD: begin
				ram_raddr_a = {row_q, col_q};
			end
			default: begin
			end
		endcase
	end

	ssum_reach_ram #(
		.AW(AW)
	) u_reach (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.raddr_a(ram_raddr_a),
		.raddr_b(ram_raddr_b),
		.rdata_a(rd_a),
		.rdata_b(rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			cnt_q      <= '0;
			n_q        <= '0;
			row_q      <= '0;
			col_q      <= '0;
			idx_q      <= '0;
			flags_q    <= '0;
			nosol_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
			res_q      <= '0;
		end else begin
			// while emitting, the output register is handled in ST_EMIT
			if (m_tvalid_q && m_tready && state_q != ST_EMIT) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (s_tvalid) begin
						if (s_tlast) begin
							n_q     <= cnt_next;
							cnt_q   <= '0;
							row_q   <= '0;
							col_q   <= '0;
							idx_q   <= '0;
							nosol_q <= too_big;
							state_q <= too_big ? ST_EMIT : ST_ROW0;
						end else begin
							cnt_q <= cnt_next;
						end
					end
				end
				ST_ROW0: begin
					if (col_q == tgt_c) begin
						col_q   <= '0;
						row_q   <= RW'(1);
						state_q <= ST_WRD;
					end else begin
						col_q <= col_q + CW'(1);
					end
				end
				ST_WRD: begin
					state_q <= ST_FILL0;
				end
				ST_FILL0: begin
					if (col_q == tgt_c) begin
						if (row_q == n_q) begin
							state_q <= ST_CHK_RD;
						end else begin
							row_q   <= row_q + RW'(1);
							col_q   <= '0;
							state_q <= ST_WRD;
						end
					end else begin
						col_q   <= CW'(1);
						state_q <= ST_FRD;
					end
				end
				ST_FRD: begin
					state_q <= ST_FWR;
				end
				ST_FWR: begin
					if (col_q == tgt_c) begin
						if (row_q == n_q) begin
							state_q <= ST_CHK_RD;
						end else begin
							row_q   <= row_q + RW'(1);
							col_q   <= '0;
							state_q <= ST_WRD;
						end
					end else begin
						col_q   <= col_q + CW'(1);
						state_q <= ST_FRD;
					end
				end
				ST_CHK_RD: begin
					state_q <= ST_CHK_EV;
				end
				ST_CHK_EV: begin
					flags_q <= '0;
					if (!rd_a) begin
						nosol_q <= 1'b1;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_TB_RD;
					end
				end
				ST_TB_RD: begin
					if (col_q == '0 || row_q == '0) begin
						idx_q   <= '0;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_TB_EV;
					end
				end
				ST_TB_EV: begin
					// not reachable without this item, so it is in the subset
					if (!rd_a) begin
						flags_q[w_raddr] <= 1'b1;
						col_q            <= diff[CW-1:0];
					end
					row_q   <= rowm1;
					state_q <= ST_TB_RD;
				end
				ST_EMIT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						if (nosol_q) begin
							res_q.found       <= 1'b0;
							res_q.item_index  <= '0;
							res_q.chosen      <= 1'b0;
							res_q.last_result <= 1'b1;
							state_q           <= ST_LOAD;
						end else begin
							res_q.found       <= 1'b1;
							res_q.item_index  <= INDEX_W'(idx_q);
							res_q.chosen      <= flags_q[idx_q];
							res_q.last_result <= emit_last;
							idx_q             <= idx_q + IW'(1);
							if (emit_last) begin
								state_q <= ST_LOAD;
							end
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

// ----- rtl/ssum_reach_ram.sv -----
// Reachability bit table: one write port, two registered read ports.
module ssum_reach_ram #(
	parameter int AW = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output logic          rdata_a,
	output logic          rdata_b
);

	logic mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ----- rtl/ssum_checker.sv -----
// Port-level checks for the subset sum solver, bound to the top level.
module ssum_checker
	import ssum_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  s_tlast,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic                  m_tuser,
	input logic                  m_tlast
);

	// a stalled result holds still
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result changed");

	// a no-solution result is always the only and final one
	a_nosol_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast && m_tdata == '0)
		else $error("no-solution result malformed");

	// the final item's transfer starts solving, so input closes next cycle
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input open right after final item");

	// a non-final result on show means the run is still emitting
	a_busy_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input open during result emission");

endmodule

bind subset_sum_solver_core ssum_checker u_ssum_checker (.*);
